### sv/tspe_pkg.sv
`default_nettype none

package tspe_pkg;

   // screen size in whole units, per axis
   localparam int GRID_WIDTH  = 1024;
   localparam int GRID_HEIGHT = 1024;

   localparam int COORD_W = 14;
   localparam int RADIUS_W = 16;
   localparam int POS_W = 19;
   localparam int UNIT_W = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAJOR_RADIUS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MINOR_RADIUS = CSR_INDEX_W'(1);

   // phase: 2^24 units per turn
   localparam int PHASE_W = 24;
   // remainder term n*B stays below 2^26
   localparam int REM_W = 26;
   localparam int RECIP_W = 28;
   localparam int REM_PROD_W = REM_W + RECIP_W;

   localparam int W_LOG = $clog2(GRID_WIDTH);
   localparam int W_SHIFT = REM_W + W_LOG;
   localparam longint W_MULA = (64'd1 << 20) / GRID_WIDTH;
   localparam longint W_MULB = (64'd1 << 20) % GRID_WIDTH;
   localparam longint W_RECIP = ((64'd1 << W_SHIFT) + GRID_WIDTH - 1) / GRID_WIDTH;

   localparam int H_LOG = $clog2(GRID_HEIGHT);
   localparam int H_SHIFT = REM_W + H_LOG;
   localparam longint H_MULA = (64'd1 << 20) / GRID_HEIGHT;
   localparam longint H_MULB = (64'd1 << 20) % GRID_HEIGHT;
   localparam longint H_RECIP = ((64'd1 << H_SHIFT) + GRID_HEIGHT - 1) / GRID_HEIGHT;

   // rotator
   localparam int ITER = 18;
   localparam int CW = 27;
   localparam int AW = 26;
   localparam logic signed [CW-1:0] GAIN_INIT = CW'(10188014);

   localparam logic signed [AW-1:0] ARC_TAB [ITER] = '{
      AW'(2097152), AW'(1238021), AW'(654136), AW'(332050), AW'(166669),
      AW'(83416), AW'(41718), AW'(20860), AW'(10430), AW'(5215), AW'(2608),
      AW'(1304), AW'(652), AW'(326), AW'(163), AW'(81), AW'(41), AW'(20)
   };

   // front end 4, rotator ITER, back end 5
   localparam int LATENCY = ITER + 9;

   function automatic logic signed [UNIT_W-1:0] to_q14(input logic signed [CW-1:0] x);
      logic signed [CW-1:0] v;
      v = (x + CW'(512)) >>> 10;
      if (v > CW'(16384))
         return UNIT_W'(16384);
      else if (v < -CW'(16384))
         return -UNIT_W'(16384);
      else
         return UNIT_W'(v);
   endfunction

endpackage

`default_nettype wire

### sv/torus_surface_point_evaluator_unit.sv
`default_nettype none

// Torus surface point evaluator.
// Input: pulse start with req_u_coord / req_v_coord (Q10.4); busy stays low,
// so a new coordinate pair may be given in every cycle.
// Output: rsp_valid strobes for one cycle with position (Q10.8), unit
// normal and both tangents (Q1.14). The receiver takes each result in
// that cycle; there is no back-pressure.
// Four stages of phase arithmetic (reciprocal multiply for the screen
// size), eighteen rotator stages (one CORDIC step each, theta and phi side
// by side), then five stages of rounding, products and ring radius.
// Throughput is one item per cycle.
// Configuration: csr_valid/csr_ready write major radius (index 0) and
// minor radius (index 1); csr_ready is always high, other indexes are
// dropped. Write only with no item in flight.
// Reset (synchronous) clears both radii and flushes all pipeline valids.

module torus_surface_point_evaluator_unit (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire logic [tspe_pkg::COORD_W-1:0] req_u_coord,
   input  wire logic [tspe_pkg::COORD_W-1:0] req_v_coord,
   output logic rsp_valid,
   output logic signed [tspe_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [tspe_pkg::POS_W-1:0] rsp_pos_y,
   output logic signed [tspe_pkg::POS_W-1:0] rsp_pos_z,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_norm_x,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_norm_y,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_norm_z,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ttan_x,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ttan_y,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ttan_z,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ptan_x,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ptan_y,
   output logic signed [tspe_pkg::UNIT_W-1:0] rsp_ptan_z,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [tspe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tspe_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int PW = tspe_pkg::PHASE_W;
   localparam int CW = tspe_pkg::CW;
   localparam int AW = tspe_pkg::AW;
   localparam int UW = tspe_pkg::UNIT_W;
   localparam int IT = tspe_pkg::ITER;
   localparam int LAT = tspe_pkg::LATENCY;

   localparam longint MULA [2] = '{tspe_pkg::W_MULA, tspe_pkg::H_MULA};
   localparam longint MULB [2] = '{tspe_pkg::W_MULB, tspe_pkg::H_MULB};
   localparam longint RECIP [2] = '{tspe_pkg::W_RECIP, tspe_pkg::H_RECIP};
   localparam int SHIFT [2] = '{tspe_pkg::W_SHIFT, tspe_pkg::H_SHIFT};

   logic [tspe_pkg::RADIUS_W-1:0] major_ff, minor_ff;
   logic [LAT:1] vld_ff;
   logic [tspe_pkg::COORD_W-1:0] coord [2];

   // lane 0 is theta, lane 1 is phi
   logic signed [UW-1:0] cos_ff [2];
   logic signed [UW-1:0] sin_ff [2];

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign coord[0] = req_u_coord;
   assign coord[1] = req_v_coord;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= '0;
         minor_ff <= '0;
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], start};
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tspe_pkg::CSR_MAJOR_RADIUS: major_ff <= csr_data;
               tspe_pkg::CSR_MINOR_RADIUS: minor_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_lane
      logic [PW-1:0] na_ff, na2_ff, p_ff;
      logic [tspe_pkg::REM_W-1:0] nb_ff;
      logic [tspe_pkg::REM_PROD_W-1:0] xm_ff;
      logic [PW-1:0] p_rnd, a_wrap;
      logic [1:0] q_in;
      logic signed [CW-1:0] cx_ff [IT+1];
      logic signed [CW-1:0] cy_ff [IT+1];
      logic signed [AW-1:0] ca_ff [IT+1];
      logic [1:0] q_ff [IT+1];
      logic signed [UW-1:0] c0, s0;

      // split phase into nearest quarter turn and a residual
      assign p_rnd = p_ff + PW'(1 << (PW - 3));
      assign q_in = p_rnd[PW-1:PW-2];
      assign a_wrap = p_ff - {q_in, (PW - 2)'(0)};
      assign c0 = tspe_pkg::to_q14(cx_ff[IT]);
      assign s0 = tspe_pkg::to_q14(cy_ff[IT]);

      always_ff @(posedge clock) begin
         // coord*2^20/size = coord*A + (coord*B)/size, the latter by reciprocal
         na_ff <= PW'({10'b0, coord[g]} * PW'(MULA[g]));
         nb_ff <= tspe_pkg::REM_W'(coord[g]) * tspe_pkg::REM_W'(MULB[g]);
         xm_ff <= tspe_pkg::REM_PROD_W'(nb_ff)
                * tspe_pkg::REM_PROD_W'(RECIP[g]);
         na2_ff <= na_ff;
         p_ff <= na2_ff + PW'(xm_ff >> SHIFT[g]);
         cx_ff[0] <= tspe_pkg::GAIN_INIT;
         cy_ff[0] <= '0;
         ca_ff[0] <= AW'($signed(a_wrap));
         q_ff[0] <= q_in;
         case (q_ff[IT])
            2'd0: begin
               cos_ff[g] <= c0;
               sin_ff[g] <= s0;
            end
            2'd1: begin
               cos_ff[g] <= -s0;
               sin_ff[g] <= c0;
            end
            2'd2: begin
               cos_ff[g] <= -c0;
               sin_ff[g] <= -s0;
            end
            default: begin
               cos_ff[g] <= s0;
               sin_ff[g] <= -c0;
            end
         endcase
      end

      for (genvar i = 0; i < IT; i++) begin : g_step
         always_ff @(posedge clock) begin
            q_ff[i+1] <= q_ff[i];
            if (!ca_ff[i][AW-1]) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               ca_ff[i+1] <= ca_ff[i] - tspe_pkg::ARC_TAB[i];
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               ca_ff[i+1] <= ca_ff[i] + tspe_pkg::ARC_TAB[i];
            end
         end
      end
   end

   // back end
   logic signed [32:0] rcp_ff, rsp_ff;
   logic signed [31:0] cpct_ff, cpst_ff, spct_ff, spst_ff;
   logic signed [UW-1:0] ct2_ff, st2_ff, cp2_ff, sp2_ff;
   logic signed [33:0] ring_ff;
   logic signed [tspe_pkg::POS_W-1:0] posy3_ff, posy4_ff;
   logic signed [UW-1:0] nx3_ff, nz3_ff, px3_ff, pz3_ff;
   logic signed [UW-1:0] ct3_ff, st3_ff, cp3_ff, sp3_ff;
   logic signed [UW-1:0] nx4_ff, nz4_ff, px4_ff, pz4_ff;
   logic signed [UW-1:0] ct4_ff, st4_ff, cp4_ff, sp4_ff;
   logic signed [49:0] rct_ff, rst_ff;
   logic signed [tspe_pkg::POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [UW-1:0] norm_x_ff, norm_y_ff, norm_z_ff;
   logic signed [UW-1:0] ttan_x_ff, ttan_z_ff;
   logic signed [UW-1:0] ptan_x_ff, ptan_y_ff, ptan_z_ff;

   always_ff @(posedge clock) begin
      rcp_ff <= 33'($signed({1'b0, minor_ff})) * 33'(cos_ff[1]);
      rsp_ff <= 33'($signed({1'b0, minor_ff})) * 33'(sin_ff[1]);
      cpct_ff <= 32'(cos_ff[1]) * 32'(cos_ff[0]);
      cpst_ff <= 32'(cos_ff[1]) * 32'(sin_ff[0]);
      spct_ff <= 32'(sin_ff[1]) * 32'(cos_ff[0]);
      spst_ff <= 32'(sin_ff[1]) * 32'(sin_ff[0]);
      ct2_ff <= cos_ff[0];
      st2_ff <= sin_ff[0];
      cp2_ff <= cos_ff[1];
      sp2_ff <= sin_ff[1];

      ring_ff <= 34'($signed({2'b0, major_ff, 14'b0})) + 34'(rcp_ff);
      posy3_ff <= tspe_pkg::POS_W'((rsp_ff + 33'sd8192) >>> 14);
      nx3_ff <= UW'((cpct_ff + 32'sd8192) >>> 14);
      nz3_ff <= UW'((cpst_ff + 32'sd8192) >>> 14);
      // round the negated product, not negate the rounded one
      px3_ff <= UW'((-33'(spct_ff) + 33'sd8192) >>> 14);
      pz3_ff <= UW'((-33'(spst_ff) + 33'sd8192) >>> 14);
      ct3_ff <= ct2_ff;
      st3_ff <= st2_ff;
      cp3_ff <= cp2_ff;
      sp3_ff <= sp2_ff;

      rct_ff <= 50'(ring_ff) * 50'(ct3_ff);
      rst_ff <= 50'(ring_ff) * 50'(st3_ff);
      posy4_ff <= posy3_ff;
      nx4_ff <= nx3_ff;
      nz4_ff <= nz3_ff;
      px4_ff <= px3_ff;
      pz4_ff <= pz3_ff;
      ct4_ff <= ct3_ff;
      st4_ff <= st3_ff;
      cp4_ff <= cp3_ff;
      sp4_ff <= sp3_ff;

      pos_x_ff <= tspe_pkg::POS_W'((rct_ff + 50'sd134217728) >>> 28);
      pos_z_ff <= tspe_pkg::POS_W'((rst_ff + 50'sd134217728) >>> 28);
      pos_y_ff <= posy4_ff;
      norm_x_ff <= nx4_ff;
      norm_y_ff <= sp4_ff;
      norm_z_ff <= nz4_ff;
      ttan_x_ff <= -st4_ff;
      ttan_z_ff <= ct4_ff;
      ptan_x_ff <= px4_ff;
      ptan_y_ff <= cp4_ff;
      ptan_z_ff <= pz4_ff;
   end

   assign rsp_valid = vld_ff[LAT];
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;
   assign rsp_norm_x = norm_x_ff;
   assign rsp_norm_y = norm_y_ff;
   assign rsp_norm_z = norm_z_ff;
   assign rsp_ttan_x = ttan_x_ff;
   assign rsp_ttan_y = '0;
   assign rsp_ttan_z = ttan_z_ff;
   assign rsp_ptan_x = ptan_x_ff;
   assign rsp_ptan_y = ptan_y_ff;
   assign rsp_ptan_z = ptan_z_ff;

endmodule

`default_nettype wire

### sv/tspe_checker.sv
`default_nettype none

module tspe_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic signed [tspe_pkg::UNIT_W-1:0] rsp_norm_y,
   input wire logic signed [tspe_pkg::UNIT_W-1:0] rsp_ttan_x,
   input wire logic signed [tspe_pkg::UNIT_W-1:0] rsp_ptan_y
);

   // every transfer in gives exactly one result
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(tspe_pkg::LATENCY) rsp_valid)
      else $error("result missing after transfer in");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, tspe_pkg::LATENCY))
      else $error("result without transfer in");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_y <= 16384 && rsp_norm_y >= -16384
                  && rsp_ttan_x <= 16384 && rsp_ttan_x >= -16384
                  && rsp_ptan_y <= 16384 && rsp_ptan_y >= -16384))
      else $error("sine or cosine outside unit range");

   a_never_busy : assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

bind torus_surface_point_evaluator_unit tspe_checker u_tspe_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_norm_y(rsp_norm_y),
   .rsp_ttan_x(rsp_ttan_x),
   .rsp_ptan_y(rsp_ptan_y)
);

`default_nettype wire
